### src/rmcp_pkg.sv
// rmcp_pkg: shared types, constants and helpers of the rmc sentence parser
`timescale 1ns / 1ps

package rmcp_pkg;

    localparam int MAX_FIELD_CHARS_DEF = 16;

    // minute fractions kept to this many digits
    localparam int FRAC_DIGITS = 4;
    localparam int FRAC_SCALE  = 10 ** FRAC_DIGITS;
    localparam int FRAC_W      = $clog2(FRAC_SCALE);

    localparam int DEG_W = 10;
    localparam int INT_W = 20;
    localparam int PAIR_W = 7;
    localparam logic [INT_W-1:0] INT_SAT = INT_W'(999999);

    // header match position
    localparam logic [2:0] HDR_START   = 3'd1;
    localparam logic [2:0] HDR_MATCHED = 3'd6;
    localparam logic [2:0] HDR_REJECT  = 3'd7;

    localparam logic [3:0] FLD_NONE   = 4'd0;
    localparam logic [3:0] FLD_TIME   = 4'd1;
    localparam logic [3:0] FLD_STATUS = 4'd2;
    localparam logic [3:0] FLD_LAT    = 4'd3;
    localparam logic [3:0] FLD_LAT_NS = 4'd4;
    localparam logic [3:0] FLD_LON    = 4'd5;
    localparam logic [3:0] FLD_LON_EW = 4'd6;
    localparam logic [3:0] FLD_SPEED  = 4'd7;
    localparam logic [3:0] FLD_DATE   = 4'd9;
    localparam logic [3:0] FLD_LAST   = 4'd15;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_V      = 8'h56;
    localparam logic [7:0] CH_N      = 8'h4E;
    localparam logic [7:0] CH_E      = 8'h45;

    // angle limits in fraction units
    localparam int LAT_W = 27;
    localparam int LON_W = 28;
    localparam logic [LAT_W-1:0] LAT_LIM = LAT_W'(90 * 60 * FRAC_SCALE);
    localparam logic [LAT_W-1:0] LON_LIM = LAT_W'(180 * 60 * FRAC_SCALE);
    localparam int ANG_W = DEG_W + 11 + FRAC_W;

    // speed: knots to metres per hour
    localparam int SPD_W = 21;
    localparam logic [10:0] SPEED_FACTOR = 11'd1852;
    localparam logic [SPD_W-1:0] SPEED_SAT = SPD_W'(1852000);
    localparam logic [INT_W-1:0] KNOTS_SAT = INT_W'(1000);
    localparam int SPX_W = FRAC_W + 11;
    localparam int RECIP_SHIFT = 38;
    localparam longint unsigned RECIP_L =
        ((64'd1 << RECIP_SHIFT) + 64'(FRAC_SCALE) - 64'd1) / 64'(FRAC_SCALE);
    localparam int RECIP_W = 25;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

    localparam int TD_W  = 33;
    localparam int RES_W = 1 + LAT_W + LON_W + SPD_W + TD_W;

    typedef enum logic [1:0] {
        OP_NONE   = 2'd0,
        OP_FIELD  = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_COMMIT = 2'd3
    } t_op_kind;

    // one operation handed to the arithmetic pipeline: a finished field, a clear or a commit
    typedef struct packed {
        t_op_kind          kind;
        logic [3:0]        fnum;
        logic              len_nz;
        logic              len_eq1;
        logic              len_ge6;
        logic              len_ge7;
        logic              len_ge8;
        logic [DEG_W-1:0]  deg;
        logic [INT_W-1:0]  int_v;
        logic [FRAC_W-1:0] frac;
        logic              dbad;
        logic [7:0]        first_ch;
        logic [PAIR_W-1:0] p0;
        logic [PAIR_W-1:0] p1;
        logic [PAIR_W-1:0] p2;
    } t_fin_op;

    function automatic logic [7:0] rmc_tag(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd1:    ch = 8'h47;
            3'd2:    ch = 8'h50;
            3'd3:    ch = 8'h52;
            3'd4:    ch = 8'h4D;
            3'd5:    ch = 8'h43;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // weight of the k-th fraction digit
    function automatic logic [FRAC_W-1:0] frac_weight(input logic [2:0] k);
        logic [FRAC_W-1:0] w;
        w = FRAC_W'(1);
        for (int i = 0; i < FRAC_DIGITS - 1; i++) begin
            if (i < FRAC_DIGITS - 1 - int'(k)) begin
                w = FRAC_W'(w * FRAC_W'(10));
            end
        end
        return w;
    endfunction

endpackage

### src/rmcp_front.sv
// rmcp_front: per-character sentence and field scanner
`timescale 1ns / 1ps

module rmcp_front
    import rmcp_pkg::*;
#(
    parameter int MAX_FIELD_CHARS = MAX_FIELD_CHARS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    output logic       o_commit,
    output t_fin_op    o_op
);

    localparam int CW = $clog2(MAX_FIELD_CHARS + 1);

    typedef struct packed {
        logic [DEG_W-1:0]  deg;
        logic [INT_W-1:0]  int_v;
        logic [FRAC_W-1:0] frac;
        logic [2:0]        fcnt;
        logic              dot;
        logic              nstop;
        logic              dstop;
        logic              dbad;
        logic [7:0]        first_ch;
        logic [PAIR_W-1:0] p0;
        logic [PAIR_W-1:0] p1;
        logic [PAIR_W-1:0] p2;
    } t_fld;

    logic          r_active, n_active;
    logic [2:0]    r_hdr, n_hdr;
    logic [3:0]    r_fnum, n_fnum;
    logic [CW-1:0] r_cnt, n_cnt;
    t_fld          r_fld, n_fld;
    t_fin_op       r_op, n_op;

    logic       is_dig;
    logic [3:0] dval;
    logic [CW-1:0] degn;

    function automatic t_fld num_char(input t_fld f, input logic [7:0] c);
        logic [INT_W+3:0]  v;
        logic [FRAC_W+3:0] pw;
        t_fld              g;
        g  = f;
        v  = (INT_W+4)'(f.int_v) * (INT_W+4)'(10) + (INT_W+4)'(c[3:0]);
        pw = (FRAC_W+4)'(frac_weight(f.fcnt)) * (FRAC_W+4)'(c[3:0]);
        if (!f.nstop) begin
            if (c >= CH_ZERO && c <= CH_NINE) begin
                if (!f.dot) begin
                    g.int_v = (v > (INT_W+4)'(INT_SAT)) ? INT_SAT : v[INT_W-1:0];
                end else if (f.fcnt < 3'(FRAC_DIGITS)) begin
                    g.frac = f.frac + pw[FRAC_W-1:0];
                    g.fcnt = f.fcnt + 3'd1;
                end
            end else if (c == CH_DOT && !f.dot) begin
                g.dot = 1'b1;
            end else begin
                g.nstop = 1'b1;
            end
        end
        return g;
    endfunction

    assign is_dig = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    assign dval   = i_byte[3:0];
    assign degn   = (r_fnum == FLD_LAT) ? CW'(2) : CW'(3);

    always_comb begin
        n_active = r_active;
        n_hdr    = r_hdr;
        n_fnum   = r_fnum;
        n_cnt    = r_cnt;
        n_fld    = r_fld;

        n_op          = '0;
        n_op.kind     = OP_NONE;
        n_op.fnum     = r_fnum;
        n_op.len_nz   = (r_cnt != '0);
        n_op.len_eq1  = (r_cnt == CW'(1));
        n_op.len_ge6  = (r_cnt >= CW'(6));
        n_op.len_ge7  = (r_cnt >= CW'(7));
        n_op.len_ge8  = (r_cnt >= CW'(8));
        n_op.deg      = r_fld.deg;
        n_op.int_v    = r_fld.int_v;
        n_op.frac     = r_fld.frac;
        n_op.dbad     = r_fld.dbad;
        n_op.first_ch = r_fld.first_ch;
        n_op.p0       = r_fld.p0;
        n_op.p1       = r_fld.p1;
        n_op.p2       = r_fld.p2;

        if (i_accept) begin
            if (i_byte == CH_DOLLAR) begin
                n_fld     = '0;
                n_cnt     = '0;
                n_fnum    = FLD_NONE;
                n_active  = 1'b1;
                n_hdr     = HDR_START;
                n_op.kind = OP_CLEAR;
            end else if (r_active && i_byte == CH_LF) begin
                n_active = 1'b0;
                n_hdr    = '0;
                n_fld    = '0;
                n_cnt    = '0;
                n_fnum   = FLD_NONE;
                if (r_hdr == HDR_MATCHED) begin
                    n_op.kind = OP_COMMIT;
                end
            end else if (r_active && r_hdr != HDR_REJECT && r_fnum == FLD_NONE) begin
                if (i_byte == CH_COMMA) begin
                    if (r_hdr != HDR_MATCHED) begin
                        n_hdr = HDR_REJECT;
                    end else begin
                        n_fnum = FLD_TIME;
                        n_fld  = '0;
                        n_cnt  = '0;
                    end
                end else if (r_hdr < HDR_MATCHED) begin
                    n_hdr = (i_byte == rmc_tag(r_hdr)) ? r_hdr + 3'd1 : HDR_REJECT;
                end
            end else if (r_active && r_hdr != HDR_REJECT && i_byte == CH_COMMA) begin
                n_op.kind = OP_FIELD;
                n_fld     = '0;
                n_cnt     = '0;
                if (r_fnum < FLD_LAST) begin
                    n_fnum = r_fnum + 4'd1;
                end
            end else if (r_active && r_hdr != HDR_REJECT
                         && r_cnt < CW'(MAX_FIELD_CHARS)) begin
                n_cnt = r_cnt + CW'(1);
                case (r_fnum)
                    FLD_TIME, FLD_DATE: begin
                        if (r_cnt < CW'(6)) begin
                            if (is_dig) begin
                                case (r_cnt[2:1])
                                    2'd0:    n_fld.p0 = PAIR_W'(r_fld.p0 * PAIR_W'(10)
                                                        + PAIR_W'(dval));
                                    2'd1:    n_fld.p1 = PAIR_W'(r_fld.p1 * PAIR_W'(10)
                                                        + PAIR_W'(dval));
                                    default: n_fld.p2 = PAIR_W'(r_fld.p2 * PAIR_W'(10)
                                                        + PAIR_W'(dval));
                                endcase
                            end else begin
                                n_fld.dbad = 1'b1;
                            end
                        end
                    end
                    FLD_STATUS, FLD_LAT_NS, FLD_LON_EW: begin
                        if (r_cnt == '0) begin
                            n_fld.first_ch = i_byte;
                        end
                    end
                    FLD_LAT, FLD_LON: begin
                        if (r_cnt < degn) begin
                            if (!r_fld.dstop && is_dig) begin
                                n_fld.deg = DEG_W'(r_fld.deg * DEG_W'(10) + DEG_W'(dval));
                            end else begin
                                n_fld.dstop = 1'b1;
                            end
                        end else begin
                            n_fld = num_char(r_fld, i_byte);
                        end
                    end
                    FLD_SPEED: n_fld = num_char(r_fld, i_byte);
                    default: n_fld = r_fld;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_hdr    <= '0;
            r_fnum   <= FLD_NONE;
            r_cnt    <= '0;
            r_fld    <= '0;
            r_op     <= '0;
        end else begin
            r_active <= n_active;
            r_hdr    <= n_hdr;
            r_fnum   <= n_fnum;
            r_cnt    <= n_cnt;
            r_fld    <= n_fld;
            r_op     <= n_op;
        end
    end

    assign o_op     = r_op;
    assign o_commit = (n_op.kind == OP_COMMIT);

    a_reject_no_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hdr == HDR_REJECT || !r_active) |-> (r_fnum == FLD_NONE))
        else $error("field counter moved outside an accepted sentence");

endmodule

### src/rmcp_finish.sv
// rmcp_finish: field arithmetic pipeline, sentence collection and held values
`timescale 1ns / 1ps

module rmcp_finish
    import rmcp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_fin_op          i_op,
    output logic             o_res_valid,
    output logic [RES_W-1:0] o_res
);

    // stage 1
    t_fin_op            r_op1;
    logic [ANG_W-1:0]   r_ang_prod;
    logic [SPX_W-1:0]   r_spx;
    logic [SPD_W-1:0]   r_spi;
    logic               r_ksat1;
    // stage 2
    t_fin_op            r_op2;
    logic [LAT_W-1:0]   r_mag;
    logic [10:0]        r_spf;
    logic [SPD_W-1:0]   r_spi2;
    logic               r_ksat2;

    // sentence collection
    logic [TD_W-1:0]  r_ptd, n_ptd;
    logic             r_tok, n_tok, r_dok, n_dok, r_statv, n_statv;
    logic             r_latl, n_latl, r_latd, n_latd, r_latn, n_latn;
    logic             r_lonl, n_lonl, r_lond, n_lond, r_lonn, n_lonn;
    logic [LAT_W-1:0] r_latm, n_latm, r_lonm, n_lonm;
    logic [SPD_W-1:0] r_pspd, n_pspd;
    // held values
    logic [LAT_W-1:0] r_hlat, n_hlat;
    logic [LON_W-1:0] r_hlon, n_hlon;
    logic [SPD_W-1:0] r_hspd, n_hspd;
    logic [TD_W-1:0]  r_htd, n_htd;
    logic             r_res_valid, n_res_valid;
    logic [RES_W-1:0] r_res, n_res;

    logic [20:0]              ang_base;
    logic [ANG_W-1:0]         ang_sum;
    logic [LAT_W-1:0]         ang_lim;
    logic [SPX_W+RECIP_W-1:0] sp_q;
    logic [SPD_W-1:0]         spd_v;
    logic                     six, td_ok, lat_ok, lon_ok, warn;

    assign ang_base = 21'(i_op.deg) * 21'd60 + 21'(i_op.int_v);
    assign ang_sum  = r_ang_prod + ANG_W'(r_op1.frac);
    assign ang_lim  = (r_op1.fnum == FLD_LAT) ? LAT_LIM : LON_LIM;
    assign sp_q     = (SPX_W+RECIP_W)'(r_spx) * (SPX_W+RECIP_W)'(RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op1 <= '0;
            r_op2 <= '0;
        end else begin
            r_op1 <= i_op;
            r_op2 <= r_op1;
        end
        r_ang_prod <= ANG_W'(ang_base) * ANG_W'(FRAC_SCALE);
        r_spx      <= SPX_W'(i_op.frac) * SPX_W'(SPEED_FACTOR);
        r_spi      <= SPD_W'(i_op.int_v[9:0]) * SPD_W'(SPEED_FACTOR);
        r_ksat1    <= (i_op.int_v >= KNOTS_SAT);
        r_mag      <= (ang_sum > ANG_W'(ang_lim)) ? ang_lim : ang_sum[LAT_W-1:0];
        r_spf      <= sp_q[RECIP_SHIFT +: 11];
        r_spi2     <= r_spi;
        r_ksat2    <= r_ksat1;
    end

    assign spd_v = r_ksat2 ? SPEED_SAT : r_spi2 + SPD_W'(r_spf);
    assign six   = r_op2.len_ge6 && !r_op2.dbad;

    always_comb begin
        n_ptd = r_ptd;  n_tok = r_tok;  n_dok = r_dok;  n_statv = r_statv;
        n_latl = r_latl; n_latd = r_latd; n_latn = r_latn; n_latm = r_latm;
        n_lonl = r_lonl; n_lond = r_lond; n_lonn = r_lonn; n_lonm = r_lonm;
        n_pspd = r_pspd;
        n_hlat = r_hlat; n_hlon = r_hlon; n_hspd = r_hspd; n_htd = r_htd;
        n_res_valid = 1'b0;
        n_res = r_res;
        td_ok = 1'b0;
        lat_ok = 1'b0;
        lon_ok = 1'b0;
        warn = 1'b0;

        if (r_op2.kind == OP_FIELD || r_op2.kind == OP_COMMIT) begin
            case (r_op2.fnum)
                FLD_TIME: begin
                    if (six && r_op2.p0 <= PAIR_W'(23) && r_op2.p1 <= PAIR_W'(59)
                        && r_op2.p2 <= PAIR_W'(59)) begin
                        n_ptd[16:0] = r_ptd[16:0]
                            | {r_op2.p2[5:0], r_op2.p1[5:0], r_op2.p0[4:0]};
                        n_tok = 1'b1;
                    end
                end
                FLD_DATE: begin
                    if (six && r_op2.p0 >= PAIR_W'(1) && r_op2.p0 <= PAIR_W'(31)
                        && r_op2.p1 >= PAIR_W'(1) && r_op2.p1 <= PAIR_W'(12)) begin
                        n_ptd[32:17] = r_ptd[32:17]
                            | {r_op2.p2, r_op2.p1[3:0], r_op2.p0[4:0]};
                        n_dok = 1'b1;
                    end
                end
                FLD_STATUS: n_statv = r_op2.len_nz && (r_op2.first_ch == CH_V);
                FLD_LAT: begin
                    n_latl = r_op2.len_ge7;
                    n_latm = r_mag;
                end
                FLD_LAT_NS: begin
                    n_latd = r_op2.len_eq1;
                    n_latn = (r_op2.first_ch != CH_N);
                end
                FLD_LON: begin
                    n_lonl = r_op2.len_ge8;
                    n_lonm = r_mag;
                end
                FLD_LON_EW: begin
                    n_lond = r_op2.len_eq1;
                    n_lonn = (r_op2.first_ch != CH_E);
                end
                FLD_SPEED: n_pspd = spd_v;
                default: n_pspd = n_pspd;
            endcase
        end

        if (r_op2.kind == OP_COMMIT) begin
            td_ok  = n_tok && n_dok;
            lat_ok = n_latl && n_latd;
            lon_ok = n_lonl && n_lond;
            warn   = n_statv || !td_ok || !lat_ok || !lon_ok;
            if (td_ok) begin
                n_htd = n_ptd;
            end
            if (lat_ok) begin
                n_hlat = n_latn ? LAT_W'(~n_latm + LAT_W'(1)) : n_latm;
            end
            if (lon_ok) begin
                n_hlon = n_lonn ? LON_W'(~LON_W'(n_lonm) + LON_W'(1)) : LON_W'(n_lonm);
            end
            n_hspd = n_pspd;
            n_res_valid = 1'b1;
            n_res = {n_htd, n_hspd, n_hlon, n_hlat, warn};
        end

        if (r_op2.kind == OP_COMMIT || r_op2.kind == OP_CLEAR) begin
            n_ptd = '0;  n_tok = 1'b0;  n_dok = 1'b0;  n_statv = 1'b0;
            n_latl = 1'b0; n_latd = 1'b0; n_latn = 1'b0; n_latm = '0;
            n_lonl = 1'b0; n_lond = 1'b0; n_lonn = 1'b0; n_lonm = '0;
            n_pspd = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptd <= '0;  r_tok <= 1'b0;  r_dok <= 1'b0;  r_statv <= 1'b0;
            r_latl <= 1'b0; r_latd <= 1'b0; r_latn <= 1'b0; r_latm <= '0;
            r_lonl <= 1'b0; r_lond <= 1'b0; r_lonn <= 1'b0; r_lonm <= '0;
            r_pspd <= '0;
            r_hlat <= '0; r_hlon <= '0; r_hspd <= '0; r_htd <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_ptd <= n_ptd;  r_tok <= n_tok;  r_dok <= n_dok;  r_statv <= n_statv;
            r_latl <= n_latl; r_latd <= n_latd; r_latn <= n_latn; r_latm <= n_latm;
            r_lonl <= n_lonl; r_lond <= n_lond; r_lonn <= n_lonn; r_lonm <= n_lonm;
            r_pspd <= n_pspd;
            r_hlat <= n_hlat; r_hlon <= n_hlon; r_hspd <= n_hspd; r_htd <= n_htd;
            r_res_valid <= n_res_valid;
        end
        r_res <= n_res;
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

### src/rmcp_fifo2.sv
// rmcp_fifo2: two-entry result buffer between the parser and the output stream
`timescale 1ns / 1ps

module rmcp_fifo2 #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data,
    output logic [1:0]       o_count
);

    logic [WIDTH-1:0] r_head, n_head, r_tail, n_tail;
    logic [1:0]       r_count, n_count;
    logic             pop;

    assign pop = i_pop && (r_count != 2'd0);

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count + 2'(i_push) - 2'(pop);
        if (pop) begin
            if (r_count == 2'd2) begin
                n_head = r_tail;
            end else if (i_push) begin
                n_head = i_data;
            end
        end else if (i_push && r_count == 2'd0) begin
            n_head = i_data;
        end
        if (i_push && ((r_count == 2'd1 && !pop) || (r_count == 2'd2 && pop))) begin
            n_tail = i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
        r_head <= n_head;
        r_tail <= n_tail;
    end

    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_head;
    assign o_count = r_count;

endmodule

### src/nmea_rmc_sentence_parser.sv
// nmea_rmc_sentence_parser: top level of the rmc sentence parser
//
//  channel   dir  word                       notes
//  s_axis    in   8 bit rx_byte              one character per word
//  m_axis    out  112 bit fix result         one word per accepted sentence
//
//  one character is taken per cycle, back to back, while s_axis_tready is high
//  a result goes through the op register, both arithmetic stages, the result register
//  up to two results wait in the output buffer; s_axis_tready drops while two are owed
//  reset is synchronous and clears all held values
`timescale 1ns / 1ps

module nmea_rmc_sentence_parser
    import rmcp_pkg::*;
#(
    parameter int MAX_FIELD_CHARS = MAX_FIELD_CHARS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,  // rx_byte[7:0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // fix_warning, latitude_units, longitude_units, speed_m_per_h, utc_hour,
    // utc_minute, utc_second, day_of_month, month_number, year_two_digit, zero pad
    output logic [111:0] m_axis_tdata
);

    logic             accept, commit, pop;
    t_fin_op          op;
    logic             res_valid;
    logic [RES_W-1:0] res;
    logic [RES_W-1:0] out_data;
    logic [1:0]       buf_count;
    logic [1:0]       r_credit, n_credit;

    assign accept = s_axis_tvalid && s_axis_tready;
    assign pop    = m_axis_tvalid && m_axis_tready;

    rmcp_front #(
        .MAX_FIELD_CHARS(MAX_FIELD_CHARS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (s_axis_tdata),
        .o_commit (commit),
        .o_op     (op)
    );

    rmcp_finish u_finish (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (op),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    rmcp_fifo2 #(
        .WIDTH(RES_W)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .i_pop   (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_data  (out_data),
        .o_count (buf_count)
    );

    // results owed: in the pipeline or buffered
    assign n_credit = r_credit + 2'(commit) - 2'(pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit <= 2'd0;
        end else begin
            r_credit <= n_credit;
        end
    end

    assign s_axis_tready = (r_credit != 2'd2);
    assign m_axis_tdata  = {{(112 - RES_W){1'b0}}, out_data};

    a_credit_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_credit <= 2'd2)
        else $error("more than two results owed");

    a_buf_within_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        buf_count <= r_credit)
        else $error("buffered results exceed owed count");

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> (buf_count != 2'd2))
        else $error("result arrived at a full buffer");

endmodule

### tb/rmc_fix_checker.sv
// rmc_fix_checker: predicts rmc fix words from accepted characters and checks the output words
`timescale 1ns / 1ps

module rmc_fix_checker
    import rmcp_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_char_valid,
    input  logic         i_char_ready,
    input  logic [7:0]   i_char,
    input  logic         i_fix_valid,
    input  logic         i_fix_ready,
    input  logic [111:0] i_fix,
    output int           o_fail_count,
    output int           o_fixes_owed
);

    typedef struct {
        bit        warn;
        bit [26:0] lat;
        bit [27:0] lon;
        bit [20:0] spd;
        bit [4:0]  hr;
        bit [5:0]  mi;
        bit [5:0]  se;
        bit [4:0]  dy;
        bit [3:0]  mo;
        bit [6:0]  yr;
    } fix_t;

    fix_t fix_q[$];
    string tag = "GPRMC";

    bit        active;
    bit [2:0]  hdr;
    int        fnum, fcnt, fdc;
    bit [31:0] deg, macc, frac;
    bit        dot, nstop, dstop, dbad;
    bit [7:0]  first;
    bit [63:0] pend;
    bit        stat_v, lat_len_ok, lat_dir_ok, lat_neg, lon_len_ok, lon_dir_ok, lon_neg;
    bit [63:0] lat_mag, lon_mag, pspeed;
    bit [26:0] held_lat;
    bit [27:0] held_lon;
    bit [20:0] held_spd;
    bit [32:0] held_td;
    int        fails;

    function automatic bit is_dig(bit [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic bit [63:0] pow10(int n);
        bit [63:0] r;
        r = 1;
        for (int i = 0; i < n; i++) r = r * 10;
        return r;
    endfunction

    task clear_field();
        fcnt = 0; deg = 0; macc = 0; fdc = 0; frac = 0;
        dot = 0; nstop = 0; dstop = 0; dbad = 0; first = 0;
    endtask

    task clear_sentence();
        clear_field();
        fnum = 0; pend = 0; stat_v = 0;
        lat_len_ok = 0; lat_dir_ok = 0; lat_neg = 0;
        lon_len_ok = 0; lon_dir_ok = 0; lon_neg = 0;
        lat_mag = 0; lon_mag = 0; pspeed = 0;
    endtask

    task number_char(bit [7:0] c);
        bit [31:0] v;
        if (nstop) return;
        if (is_dig(c)) begin
            if (!dot) begin
                v = macc * 10 + (c - CH_ZERO);
                macc = (v > 999999) ? 999999 : v;
            end else if (fdc < FRAC_DIGITS) begin
                frac = frac * 10 + (c - CH_ZERO);
                fdc++;
            end
        end else if (c == CH_DOT && !dot) begin
            dot = 1;
        end else begin
            nstop = 1;
        end
    endtask

    function automatic bit [63:0] scaled();
        return 64'(macc) * pow10(FRAC_DIGITS) + 64'(frac) * pow10(FRAC_DIGITS - fdc);
    endfunction

    function automatic bit [63:0] angle_mag(bit [63:0] max_deg, bit [63:0] fmax);
        bit [63:0] lim, v;
        lim = max_deg * 60 * pow10(FRAC_DIGITS);
        v = 64'(deg) * 60 * pow10(FRAC_DIGITS) + scaled();
        if (lim > fmax) lim = fmax;
        return (v > lim) ? lim : v;
    endfunction

    task field_char(bit [7:0] c);
        int idx, degn;
        idx = fcnt;
        degn = (fnum == FLD_LAT) ? 2 : 3;
        if (idx >= MAX_FIELD_CHARS_DEF) return;
        fcnt++;
        case (fnum)
            FLD_TIME, FLD_DATE: begin
                if (idx < 6) begin
                    if (is_dig(c)) macc = macc * 10 + (c - CH_ZERO);
                    else dbad = 1;
                end
            end
            FLD_STATUS, FLD_LAT_NS, FLD_LON_EW: begin
                if (idx == 0) first = c;
            end
            FLD_LAT, FLD_LON: begin
                if (idx < degn) begin
                    if (!dstop && is_dig(c)) deg = deg * 10 + (c - CH_ZERO);
                    else dstop = 1;
                end else begin
                    number_char(c);
                end
            end
            FLD_SPEED: number_char(c);
            default: ;
        endcase
    endtask

    task finish_field();
        bit [63:0] a, b, d, v;
        bit six;
        a = macc / 10000; b = (macc / 100) % 100; d = macc % 100;
        six = fcnt >= 6 && !dbad;
        case (fnum)
            FLD_TIME: if (six && a <= 23 && b <= 59 && d <= 59)
                pend |= a | (b << 5) | (d << 11) | (64'd1 << 33);
            FLD_DATE: if (six && a >= 1 && a <= 31 && b >= 1 && b <= 12)
                pend |= (a << 17) | (b << 22) | (d << 26) | (64'd1 << 34);
            FLD_STATUS: stat_v = fcnt > 0 && first == CH_V;
            FLD_LAT: begin
                lat_len_ok = fcnt >= 7;
                lat_mag = angle_mag(90, 64'h3FFFFFF);
            end
            FLD_LAT_NS: begin
                lat_dir_ok = fcnt == 1;
                lat_neg = first != CH_N;
            end
            FLD_LON: begin
                lon_len_ok = fcnt >= 8;
                lon_mag = angle_mag(180, 64'h7FFFFFF);
            end
            FLD_LON_EW: begin
                lon_dir_ok = fcnt == 1;
                lon_neg = first != CH_E;
            end
            FLD_SPEED: begin
                v = scaled() * 1852 / pow10(FRAC_DIGITS);
                pspeed = (v > 1852000) ? 1852000 : v;
            end
            default: ;
        endcase
        clear_field();
    endtask

    task take_char(bit [7:0] c);
        bit td_ok, lat_ok, lon_ok;
        fix_t f;
        if (c == CH_DOLLAR) begin
            clear_sentence();
            active = 1;
            hdr = HDR_START;
            return;
        end
        if (!active) return;
        if (c == CH_LF) begin
            active = 0;
            if (hdr != HDR_MATCHED) begin
                hdr = 0;
                return;
            end
            hdr = 0;
            finish_field();
            td_ok = pend[33] && pend[34];
            lat_ok = lat_len_ok && lat_dir_ok;
            lon_ok = lon_len_ok && lon_dir_ok;
            if (td_ok) held_td = pend[32:0];
            if (lat_ok) held_lat = lat_neg ? 27'(-lat_mag) : 27'(lat_mag);
            if (lon_ok) held_lon = lon_neg ? 28'(-lon_mag) : 28'(lon_mag);
            held_spd = pspeed[20:0];
            f.warn = stat_v || !td_ok || !lat_ok || !lon_ok;
            f.lat = held_lat; f.lon = held_lon; f.spd = held_spd;
            f.hr = held_td[4:0]; f.mi = held_td[10:5]; f.se = held_td[16:11];
            f.dy = held_td[21:17]; f.mo = held_td[25:22]; f.yr = held_td[32:26];
            fix_q.push_back(f);
            clear_sentence();
            return;
        end
        if (hdr == HDR_REJECT) return;
        if (fnum == FLD_NONE) begin
            if (c == CH_COMMA) begin
                if (hdr != HDR_MATCHED) begin
                    hdr = HDR_REJECT;
                end else begin
                    fnum = FLD_TIME;
                    clear_field();
                end
            end else if (hdr >= HDR_START && hdr < HDR_MATCHED) begin
                if (c == tag[hdr-1]) hdr++;
                else hdr = HDR_REJECT;
            end
            return;
        end
        if (c == CH_COMMA) begin
            finish_field();
            if (fnum < FLD_LAST) fnum++;
            return;
        end
        field_char(c);
    endtask

    task chk(string name, longint unsigned e, longint unsigned a);
        if (e != a) begin
            $error("%s: expected %0d, got %0d", name, e, a);
            fails++;
        end
    endtask

    task check_fix(logic [111:0] w);
        fix_t e;
        if (fix_q.size() == 0) begin
            $error("fix word with none expected: %h", w);
            fails++;
            return;
        end
        e = fix_q.pop_front();
        chk("fix_warning", e.warn, w[0]);
        chk("latitude_units", e.lat, w[27:1]);
        chk("longitude_units", e.lon, w[55:28]);
        chk("speed_m_per_h", e.spd, w[76:56]);
        chk("utc_hour", e.hr, w[81:77]);
        chk("utc_minute", e.mi, w[87:82]);
        chk("utc_second", e.se, w[93:88]);
        chk("day_of_month", e.dy, w[98:94]);
        chk("month_number", e.mo, w[102:99]);
        chk("year_two_digit", e.yr, w[109:103]);
        chk("zero pad", 0, w[111:110]);
    endtask

    initial begin
        fails = 0;
        o_fail_count = 0;
        o_fixes_owed = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_sentence();
            active = 0; hdr = 0;
            held_lat = 0; held_lon = 0; held_spd = 0; held_td = 0;
            fix_q.delete();
        end else begin
            if (i_fix_valid && i_fix_ready) check_fix(i_fix);
            if (i_char_valid && i_char_ready) take_char(i_char);
        end
        o_fail_count <= fails;
        o_fixes_owed <= fix_q.size();
    end

endmodule

### tb/tb_top.sv
// tb_top: character stimulus, output stalling and verdict for the rmc sentence parser
`timescale 1ns / 1ps

module tb_top
    import rmcp_pkg::*;
;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata;   // rx_byte[7:0]
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [111:0] m_axis_tdata;   // fix_warning .. year_two_digit, zero pad

    int fail_count, fixes_owed;
    int idle_pct, stall_pct, sent, cycles, held, base;
    bit long_hold;
    bit [7:0] txq[$];

    nmea_rmc_sentence_parser dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    rmc_fix_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_char_valid (s_axis_tvalid),
        .i_char_ready (s_axis_tready),
        .i_char       (s_axis_tdata),
        .i_fix_valid  (m_axis_tvalid),
        .i_fix_ready  (m_axis_tready),
        .i_fix        (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_fixes_owed (fixes_owed)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > 800000) begin
                $display("tb_top: FAIL");
                $finish;
            end
        end
    end

    // output side stalling, with one long hold-off
    initial begin
        m_axis_tready = 0;
        held = 0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                m_axis_tready <= 0;
            end else if (long_hold && held < 400) begin
                m_axis_tready <= 0;
                held++;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task put(input bit [7:0] b);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sent++;
    endtask

    task flush();
        while (txq.size() > 0) put(txq.pop_front());
    endtask

    task add(string s);
        for (int i = 0; i < s.len(); i++) txq.push_back(s[i]);
    endtask

    task junk(int n);
        for (int i = 0; i < n; i++) txq.push_back(8'($urandom_range(255)));
    endtask

    task digits(int n);
        for (int i = 0; i < n; i++) txq.push_back(8'(CH_ZERO + $urandom_range(9)));
    endtask

    task dir_field(string good0, string good1);
        case ($urandom_range(9))
            0: add("");
            1: add({good0, good1});
            2: junk(1);
            3, 4, 5: add(good1);
            default: add(good0);
        endcase
    endtask

    task angle_field(int degw, int maxdeg);
        if ($urandom_range(9) == 0) begin
            junk($urandom_range(12));
        end else begin
            if (degw == 2) add($sformatf("%02d", $urandom_range(maxdeg)));
            else add($sformatf("%03d", $urandom_range(maxdeg)));
            add($sformatf("%02d", $urandom_range(99)));
            if ($urandom_range(7) != 0) add(".");
            digits($urandom_range(7));
        end
    endtask

    task random_sentence();
        case ($urandom_range(19))
            0: add("$GPGGA");
            1: add("$GPRM");
            2: begin add("$"); junk($urandom_range(6)); end
            default: add("$GPRMC");
        endcase
        add(",");
        if ($urandom_range(9) == 0) junk($urandom_range(8));
        else add($sformatf("%02d%02d%02d.%02d", $urandom_range(25), $urandom_range(61),
                           $urandom_range(61), $urandom_range(99)));
        add(",");
        case ($urandom_range(5))
            0: add("V");
            1: add("");
            2: junk(2);
            default: add("A");
        endcase
        add(",");
        angle_field(2, $urandom_range(3) == 0 ? 99 : 89);
        add(",");
        dir_field("N", "S");
        add(",");
        angle_field(3, $urandom_range(3) == 0 ? 999 : 179);
        add(",");
        dir_field("E", "W");
        add(",");
        if ($urandom_range(9) == 0) add("");
        else if ($urandom_range(9) == 0) add($sformatf("%0d.%0d", $urandom_range(2000000),
                                                        $urandom_range(99999)));
        else add($sformatf("%0d.%0d", $urandom_range(150), $urandom_range(999)));
        if ($urandom_range(15) == 0) begin
            add("\n");
            return;
        end
        add(",");
        digits($urandom_range(4));
        add(",");
        if ($urandom_range(9) == 0) junk($urandom_range(8));
        else add($sformatf("%02d%02d%02d", $urandom_range(33), $urandom_range(13),
                           $urandom_range(99)));
        if ($urandom_range(2) == 0) add(",,A*4F\r");
        if ($urandom_range(11) == 0) junk($urandom_range(20));
        if ($urandom_range(15) != 0) add("\n");
        if ($urandom_range(4) == 0) junk($urandom_range(5));
    endtask

    initial begin
        idle_pct = 0;
        stall_pct = 0;
        long_hold = 0;
        sent = 0;
        base = 0;
        i_rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed sentences
        add("\nxy\n");
        add("$GPRMC,123519,A,4807.038,N,01131.000,E,022.4,084.4,230394,003.1,W*6A\n");
        add("$GPRMC,235959,V,9000.0000,S,18000.0000,W,999.99,,311299,,\n");
        add("$GPRMC,000000,,9959.99999,N,99999.123456,E,1000000,,010100\n");
        add("$GPRMC,240000,A,12,N,1234567,E,,,320194\n");
        add("$GPRMC,12a456,A,4807.038,NN,01131.000,,5.5,,1301xx\n");
        add("$GPRMC,123456789012345678901,A,4x07.038,N,0a131.000,E,1.2.3,,150620,a,b,");
        add("c,d,e,f,g,h,i,j,k\n");
        add("$GPGGA,1,2\n");
        add("xyz$GPR$GPRMC,1\n");
        add("$GPRMC\n");
        add("$GPRMC,112233,A,1234.5678,N,12345.6789,E,0,,010203");
        add("$GPRMC,000000,A,0000.0000,S,00000.0000,W,0.0001,,010100\n");
        txq.push_back(8'hFF);
        txq.push_back(8'h00);
        flush();
        base = sent;

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 88; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 88; end
                3: begin idle_pct = 14; stall_pct = 14; end
                default: begin idle_pct = 0; stall_pct = 0; long_hold = 1; end
            endcase
            while (sent < base + 285 * (ph + 1)) begin
                random_sentence();
                flush();
            end
        end
        s_axis_tvalid <= 0;

        while (fixes_owed != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && fixes_owed == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
